>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk while rst is low.
`define CFA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define CFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFA_ASSERT(label, clk, rst, prop, msg)
`define CFA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Widths, types and arithmetic helpers for the complex fixed-point ALU.
// ----------------------------------------------------------------------------
package cfa_pkg;

  // Operand format.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Derived widths.
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int SUM_W   = PROD_W + 1;
  localparam int QUO_W   = DATA_WIDTH + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // A classified item as it sits in the queue.
  typedef struct packed {
    op_t   op;
    logic  dz;
    data_t a_re;
    data_t a_im;
    data_t b_re;
    data_t b_im;
  } item_t;

  // A saturated result part.
  typedef struct packed {
    data_t val;
    logic  ovf;
  } sat_t;

  // One restoring division step.
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic              qbit;
  } step_t;

  // Clamp a wide signed value to the data range.
  function automatic sat_t saturate(input logic [SUM_W-1:0] v);
    sat_t s;
    logic [SUM_W-DATA_WIDTH:0] upper;
    upper = v[SUM_W-1:DATA_WIDTH-1];
    if ((~|upper) || (&upper)) begin
      s.val = data_t'(v[DATA_WIDTH-1:0]);
      s.ovf = 1'b0;
    end else begin
      s.val = v[SUM_W-1] ? DATA_MIN : DATA_MAX;
      s.ovf = 1'b1;
    end
    return s;
  endfunction

  // Bring down one dividend bit and subtract the divisor when it fits.
  function automatic step_t div_step(input logic [PROD_W-1:0] rem,
                                     input logic              dbit,
                                     input logic [PROD_W-1:0] den);
    step_t s;
    logic [PROD_W:0] t;
    t = {rem, dbit};
    if (t >= {1'b0, den}) begin
      s.rem  = PROD_W'(t - {1'b0, den});
      s.qbit = 1'b1;
    end else begin
      s.rem  = t[PROD_W-1:0];
      s.qbit = 1'b0;
    end
    return s;
  endfunction

  // Apply the sign to an unsigned quotient and clamp it.
  function automatic sat_t div_finish(input logic             neg,
                                      input logic             pre,
                                      input logic [QUO_W-1:0] q);
    sat_t s;
    if (neg) begin
      if (pre || (q > (QUO_W'(1) << (DATA_WIDTH - 1)))) begin
        s.val = DATA_MIN;
        s.ovf = 1'b1;
      end else begin
        s.val = data_t'(QUO_W'(0) - q);
        s.ovf = 1'b0;
      end
    end else begin
      if (pre || (q[QUO_W-1:DATA_WIDTH-1] != '0)) begin
        s.val = DATA_MAX;
        s.ovf = 1'b1;
      end else begin
        s.val = data_t'(q[DATA_WIDTH-1:0]);
        s.ovf = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/cfa_front.sv
// ----------------------------------------------------------------------------
// cfa_front
// Input stage: takes items, flags a zero divisor and hands them to the queue.
// ----------------------------------------------------------------------------
module cfa_front import cfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  data_t       a_re,
  input  data_t       a_im,
  input  data_t       b_re,
  input  data_t       b_im,
  output logic        push,
  output item_t       push_item,
  input  logic        q_full
);

  logic  fv;
  logic  fv_next;
  logic  load;
  item_t item;

  // The holding register frees up whenever it can move into the queue.
  assign in_stall  = fv && q_full;
  assign push      = fv && !q_full;
  assign load      = in_valid && !in_stall;
  assign push_item = item;

  always_comb begin
    fv_next = fv;
    if (load) begin
      fv_next = 1'b1;
    end else if (push) begin
      fv_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= fv_next;
    end
  end

  // Capture the item and classify it.
  always_ff @(posedge clk) begin
    if (load) begin
      item.op   <= op_t'(op);
      item.dz   <= (op_t'(op) == OP_DIV) && (b_re == '0) && (b_im == '0);
      item.a_re <= a_re;
      item.a_im <= a_im;
      item.b_re <= b_re;
      item.b_im <= b_im;
    end
  end

endmodule

>>> rtl/cfa_queue.sv
// ----------------------------------------------------------------------------
// cfa_queue
// Short FIFO between the front and the back so that each can stall alone.
// ----------------------------------------------------------------------------
module cfa_queue import cfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [QPTR_W:0]   count_next;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && pop_valid)) begin
      count_next = count + 1'b1;
    end else if (!push && pop && pop_valid) begin
      count_next = count - 1'b1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/cfa_back.sv
// ----------------------------------------------------------------------------
// cfa_back
// Execution pipeline: products, sums, rounding and a restoring divider with
// one quotient bit per stage. Every operation takes the same path length.
// ----------------------------------------------------------------------------
module cfa_back import cfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  pop_valid,
  input  item_t pop_item,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_stall,
  output data_t res_re,
  output data_t res_im,
  output logic  div_zero,
  output logic  overflow
);

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    op_t                       op;
    logic                      dz;
    logic signed [PROD_W-1:0]  p_rr;
    logic signed [PROD_W-1:0]  p_ii;
    logic signed [PROD_W-1:0]  p_ri;
    logic signed [PROD_W-1:0]  p_ir;
    logic signed [PROD_W-1:0]  p_bb;
    logic signed [PROD_W-1:0]  p_cc;
    logic signed [DATA_WIDTH:0] sum_re;
    logic signed [DATA_WIDTH:0] sum_im;
  } mul_stage_t;

  typedef struct packed {
    op_t                       op;
    logic                      dz;
    logic signed [SUM_W-1:0]   acc_re;
    logic signed [SUM_W-1:0]   acc_im;
    logic [PROD_W-1:0]         den;
    logic signed [DATA_WIDTH:0] sum_re;
    logic signed [DATA_WIDTH:0] sum_im;
  } add_stage_t;

  typedef struct packed {
    op_t               op;
    logic              dz;
    data_t             re;
    data_t             im;
    logic              ovf;
    logic              neg_re;
    logic              neg_im;
    logic              pre_re;
    logic              pre_im;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] r_re;
    logic [PROD_W-1:0] r_im;
    logic [QUO_W-1:0]  x_re;
    logic [QUO_W-1:0]  x_im;
  } div_stage_t;

  logic       en;
  logic       v1;
  logic       v2;
  mul_stage_t s1;
  add_stage_t s2;
  logic       dv [QUO_W+1];
  div_stage_t d  [QUO_W+1];
  div_stage_t d0_next;
  div_stage_t dstep [QUO_W];

  // The whole pipe advances unless a finished result is held back.
  assign en  = !out_valid || !out_stall;
  assign pop = pop_valid && en;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) begin
        dv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v1    <= pop_valid;
      v2    <= v1;
      dv[0] <= v2;
      for (int k = 0; k < QUO_W; k++) begin
        dv[k+1] <= dv[k];
      end
      out_valid <= dv[QUO_W];
    end
  end

  // Stage 1: the six products, and the plain sums.
  always_ff @(posedge clk) begin
    if (en) begin
      s1.op     <= pop_item.op;
      s1.dz     <= pop_item.dz;
      s1.p_rr   <= PROD_W'(pop_item.a_re) * PROD_W'(pop_item.b_re);
      s1.p_ii   <= PROD_W'(pop_item.a_im) * PROD_W'(pop_item.b_im);
      s1.p_ri   <= PROD_W'(pop_item.a_re) * PROD_W'(pop_item.b_im);
      s1.p_ir   <= PROD_W'(pop_item.a_im) * PROD_W'(pop_item.b_re);
      s1.p_bb   <= PROD_W'(pop_item.b_re) * PROD_W'(pop_item.b_re);
      s1.p_cc   <= PROD_W'(pop_item.b_im) * PROD_W'(pop_item.b_im);
      if (pop_item.op == OP_SUB) begin
        s1.sum_re <= (DATA_WIDTH+1)'(pop_item.a_re) - (DATA_WIDTH+1)'(pop_item.b_re);
        s1.sum_im <= (DATA_WIDTH+1)'(pop_item.a_im) - (DATA_WIDTH+1)'(pop_item.b_im);
      end else begin
        s1.sum_re <= (DATA_WIDTH+1)'(pop_item.a_re) + (DATA_WIDTH+1)'(pop_item.b_re);
        s1.sum_im <= (DATA_WIDTH+1)'(pop_item.a_im) + (DATA_WIDTH+1)'(pop_item.b_im);
      end
    end
  end

  // Stage 2: sums of products, the rounding half for multiply, the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      s2.op     <= s1.op;
      s2.dz     <= s1.dz;
      s2.sum_re <= s1.sum_re;
      s2.sum_im <= s1.sum_im;
      s2.den    <= PROD_W'(s1.p_bb + s1.p_cc);
      if (s1.op == OP_MUL) begin
        s2.acc_re <= SUM_W'(s1.p_rr) - SUM_W'(s1.p_ii) + ROUND_HALF;
        s2.acc_im <= SUM_W'(s1.p_ri) + SUM_W'(s1.p_ir) + ROUND_HALF;
      end else begin
        s2.acc_re <= SUM_W'(s1.p_rr) + SUM_W'(s1.p_ii);
        s2.acc_im <= SUM_W'(s1.p_ir) - SUM_W'(s1.p_ri);
      end
    end
  end

  // Stage 3: finish add, subtract and multiply; set up the division.
  always_comb begin
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
    logic [SUM_W-1:0]  sh_re;
    logic [SUM_W-1:0]  sh_im;
    sat_t              sr;
    sat_t              si;
    d0_next.op     = s2.op;
    d0_next.dz     = s2.dz;
    d0_next.den    = s2.den;
    d0_next.neg_re = s2.acc_re[SUM_W-1];
    d0_next.neg_im = s2.acc_im[SUM_W-1];
    mag_re = d0_next.neg_re ? PROD_W'(-s2.acc_re) : PROD_W'(s2.acc_re);
    mag_im = d0_next.neg_im ? PROD_W'(-s2.acc_im) : PROD_W'(s2.acc_im);
    d0_next.r_re   = mag_re >> (QUO_W - FRAC_BITS);
    d0_next.r_im   = mag_im >> (QUO_W - FRAC_BITS);
    d0_next.pre_re = d0_next.r_re >= s2.den;
    d0_next.pre_im = d0_next.r_im >= s2.den;
    d0_next.x_re   = {mag_re[QUO_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
    d0_next.x_im   = {mag_im[QUO_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
    sh_re = s2.acc_re >>> FRAC_BITS;
    sh_im = s2.acc_im >>> FRAC_BITS;
    unique case (s2.op)
      OP_ADD, OP_SUB: begin
        sr = saturate(SUM_W'(s2.sum_re));
        si = saturate(SUM_W'(s2.sum_im));
      end
      OP_MUL: begin
        sr = saturate(sh_re);
        si = saturate(sh_im);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    d0_next.re  = sr.val;
    d0_next.im  = si.val;
    d0_next.ovf = sr.ovf || si.ovf;
  end

  // Divider stages: each brings down one dividend bit and makes one quotient bit.
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      step_t tr;
      step_t ti;
      dstep[k] = d[k];
      tr = div_step(d[k].r_re, d[k].x_re[QUO_W-1], d[k].den);
      ti = div_step(d[k].r_im, d[k].x_im[QUO_W-1], d[k].den);
      dstep[k].r_re = tr.rem;
      dstep[k].r_im = ti.rem;
      dstep[k].x_re = {d[k].x_re[QUO_W-2:0], tr.qbit};
      dstep[k].x_im = {d[k].x_im[QUO_W-2:0], ti.qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= d0_next;
      for (int k = 0; k < QUO_W; k++) begin
        d[k+1] <= dstep[k];
      end
    end
  end

  // Output register: sign and clamp the quotients, give zero for a zero divisor, or pass earlier results on.
  always_ff @(posedge clk) begin
    sat_t qr;
    sat_t qi;
    qr = div_finish(d[QUO_W].neg_re, d[QUO_W].pre_re, d[QUO_W].x_re);
    qi = div_finish(d[QUO_W].neg_im, d[QUO_W].pre_im, d[QUO_W].x_im);
    if (en) begin
      div_zero <= d[QUO_W].dz;
      if (d[QUO_W].op != OP_DIV) begin
        res_re   <= d[QUO_W].re;
        res_im   <= d[QUO_W].im;
        overflow <= d[QUO_W].ovf;
      end else if (d[QUO_W].dz) begin
        res_re   <= '0;
        res_im   <= '0;
        overflow <= 1'b0;
      end else begin
        res_re   <= qr.val;
        res_im   <= qi.val;
        overflow <= qr.ovf || qi.ovf;
      end
    end
  end

endmodule

>>> rtl/complex_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries op, a_re, a_im, b_re and
//   b_im. The output channel (out_valid / out_stall) carries res_re, res_im,
//   div_zero and overflow. One result item comes out for every input item,
//   in order.
//   Every operation follows the same path from acceptance to out_valid,
//   including the 33-stage divider that all items pass through. Throughput is
//   one item per cycle: a holding register and a four-entry queue feed the
//   execution pipeline, which advances every cycle that its output register
//   is empty or being taken.
//   While out_stall is high with a result waiting, the execution pipeline
//   holds; the queue keeps taking items until it fills, then in_stall rises.
//   A synchronous reset empties the queue and clears every valid bit; no
//   result is in flight after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_fixed_point_alu import cfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  data_t      a_re,
  input  data_t      a_im,
  input  data_t      b_re,
  input  data_t      b_im,
  output logic       out_valid,
  input  logic       out_stall,
  output data_t      res_re,
  output data_t      res_im,
  output logic       div_zero,
  output logic       overflow
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_in;
  item_t q_out;

  // Front: capture and classify.
  cfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .push      (q_push),
    .push_item (q_in),
    .q_full    (q_full)
  );

  // Queue between the two halves.
  cfa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out)
  );

  // Back: arithmetic pipeline and output register.
  cfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_item  (q_out),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_re    (res_re),
    .res_im    (res_im),
    .div_zero  (div_zero),
    .overflow  (overflow)
  );

  // The front never writes into a full queue.
  `CFA_ASSERT(a_no_push_full, clk, rst, !(q_push && q_full), "push into full queue")
  // A zero divisor gives a zero result with no overflow.
  `CFA_ASSERT(a_dz_zero, clk, rst, (out_valid && div_zero) |-> (res_re == '0 && res_im == '0 && !overflow), "bad zero-divisor result")
  // Overflow only ever shows with a part at a bound.
  `CFA_ASSERT(a_ovf_bound, clk, rst, (out_valid && overflow) |-> (res_re == DATA_MAX || res_re == DATA_MIN || res_im == DATA_MAX || res_im == DATA_MIN), "overflow without a clamped part")
  // Nothing is offered right after reset.
  `CFA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result offered after reset")

endmodule
